// ===== sv/zpde_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zpde_pkg;

   // field widths
   localparam int PIXEL_WIDTH     = 8;
   localparam int ROW_WIDTH       = 7;
   localparam int COL_WIDTH       = 8;
   localparam int DARK_WIDTH      = 8;
   localparam int THRESH_WIDTH    = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int ZONE_COUNT      = 4;

   // frame geometry defaults
   localparam int LINE_WIDTH_DEFAULT = 256;
   localparam int FRAME_ROWS_DEFAULT = 128;

   // first row of each zone
   localparam int ZONE0_ROW_MIN = 110;
   localparam int ZONE1_ROW_MIN = 80;
   localparam int ZONE2_ROW_MIN = 60;

   // register reset values
   localparam logic [DARK_WIDTH-1:0]   DARK_LIMIT_RESET = 8'd128;
   localparam logic [THRESH_WIDTH-1:0] THRESHOLD_RESET  = 16'd4000;

   // register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DARK_ZONE0   = 3'd0,
      REG_DARK_ZONE1   = 3'd1,
      REG_DARK_ZONE2   = 3'd2,
      REG_DARK_ZONE3   = 3'd3,
      REG_THRESH_ZONE0 = 3'd4,
      REG_THRESH_ZONE1 = 3'd5,
      REG_THRESH_ZONE2 = 3'd6,
      REG_THRESH_ZONE3 = 3'd7
   } csr_index_type;

   typedef logic [1:0] zone_type;

   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel;
      logic [ROW_WIDTH-1:0]   row;
      logic [COL_WIDTH-1:0]   col;
   } req_payload_type;

   typedef struct packed {
      logic                   edge_res;
      logic [ROW_WIDTH-1:0]   center_row;
      logic [COL_WIDTH-1:0]   center_col;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== sv/zpde_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zpde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port (read returns old data on collision)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/zoned_prewitt_dark_edge_detector_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Zoned Prewitt dark-edge detector. Pixels arrive in raster order tagged with
// row and column; one request can be taken every clock unless req_stall is high.
// Each request is registered together with the two line-store reads for its
// column; the 3x3 window is then classified from that stage and the result
// lands in the output register when the stage advances. A request whose
// row or column is below 2 updates the line stores and window but yields no
// result; a request outside the frame is taken and dropped without effect.
// The line stores are plain RAMs with no clearing pass: the first two rows
// of a frame fill them before any value read from them feeds a result. When the
// result register is full and stalled, the request side stalls as soon as the
// internal stage holds a request that would produce a result.
module zoned_prewitt_dark_edge_detector_top
   import zpde_pkg::*;
#(
   parameter int LINE_WIDTH = LINE_WIDTH_DEFAULT,
   parameter int FRAME_ROWS = FRAME_ROWS_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire req_payload_type            req_payload,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output rsp_payload_type                 rsp_payload,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_wr_data
);

   localparam int AW = $clog2(LINE_WIDTH);
   localparam int CW = (AW > COL_WIDTH) ? AW : COL_WIDTH;

   // configuration registers
   logic [DARK_WIDTH-1:0]   dark_ff   [ZONE_COUNT];
   logic [THRESH_WIDTH-1:0] thresh_ff [ZONE_COUNT];

   // stage 1: registered request plus forwarding for a back-to-back column
   logic                   s1_valid_ff, s1_valid_in;
   req_payload_type        s1_ff;
   logic                   s1_fwd_ff;
   logic [PIXEL_WIDTH-1:0] s1_fwd_older_ff, s1_fwd_newer_ff;

   // window: [r*2+0] two columns back, [r*2+1] one column back
   logic [PIXEL_WIDTH-1:0] win_ff [6];

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   // control
   logic req_accept;
   logic in_frame;
   logic s1_has_result;
   logic s1_move;

   // line stores
   logic [CW-1:0]          req_col_wide, s1_col_wide;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic [PIXEL_WIDTH-1:0] older_rd, newer_rd;
   logic [PIXEL_WIDTH-1:0] top_px, mid_px, bot_px;

   // classification
   logic [ROW_WIDTH-1:0]   center_row;
   zone_type               zone;
   logic [9:0]             top_sum, bot_sum, left_sum, right_sum;
   logic signed [10:0]     dx, dy;
   logic signed [21:0]     dx_sq, dy_sq;
   logic [20:0]            energy;
   logic                   is_dark, is_strong;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ZONE_COUNT; i++) begin
            dark_ff[i]   <= DARK_LIMIT_RESET;
            thresh_ff[i] <= THRESHOLD_RESET;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_DARK_ZONE0:   dark_ff[0]   <= csr_wr_data[DARK_WIDTH-1:0];
            REG_DARK_ZONE1:   dark_ff[1]   <= csr_wr_data[DARK_WIDTH-1:0];
            REG_DARK_ZONE2:   dark_ff[2]   <= csr_wr_data[DARK_WIDTH-1:0];
            REG_DARK_ZONE3:   dark_ff[3]   <= csr_wr_data[DARK_WIDTH-1:0];
            REG_THRESH_ZONE0: thresh_ff[0] <= csr_wr_data;
            REG_THRESH_ZONE1: thresh_ff[1] <= csr_wr_data;
            REG_THRESH_ZONE2: thresh_ff[2] <= csr_wr_data;
            REG_THRESH_ZONE3: thresh_ff[3] <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // handshake and stage advance
   always_comb begin
      s1_has_result = (s1_ff.row >= ROW_WIDTH'(2)) && (s1_ff.col >= COL_WIDTH'(2));
      s1_move       = s1_valid_ff && (!s1_has_result || !rsp_valid_ff || !rsp_stall);
      req_stall     = s1_valid_ff && !s1_move;
      req_accept    = req_valid && !req_stall;
      in_frame      = (32'(req_payload.col) < 32'(LINE_WIDTH))
                   && (32'(req_payload.row) < 32'(FRAME_ROWS));
   end

   // line-store addressing
   always_comb begin
      req_col_wide = CW'(req_payload.col);
      s1_col_wide  = CW'(s1_ff.col);
      rd_addr      = req_col_wide[AW-1:0];
      wr_addr      = s1_col_wide[AW-1:0];
   end

   // older line: row-2 pixels, refilled from the newer line as it is read
   zpde_ram #(
      .WIDTH(PIXEL_WIDTH),
      .DEPTH(LINE_WIDTH)
   ) u_older_line (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (wr_addr),
      .wr_data (mid_px),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (older_rd)
   );

   // newer line: row-1 pixels
   zpde_ram #(
      .WIDTH(PIXEL_WIDTH),
      .DEPTH(LINE_WIDTH)
   ) u_newer_line (
      .clock   (clock),
      .wr_en   (s1_move),
      .wr_addr (wr_addr),
      .wr_data (s1_ff.pixel),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (newer_rd)
   );

   // column pixels, with the previous request's writes forwarded
   always_comb begin
      top_px = s1_fwd_ff ? s1_fwd_older_ff : older_rd;
      mid_px = s1_fwd_ff ? s1_fwd_newer_ff : newer_rd;
      bot_px = s1_ff.pixel;
   end

   // zone select by centre row
   always_comb begin
      center_row = s1_ff.row - ROW_WIDTH'(1);
      if (center_row >= ROW_WIDTH'(ZONE0_ROW_MIN)) begin
         zone = 2'd0;
      end else if (center_row >= ROW_WIDTH'(ZONE1_ROW_MIN)) begin
         zone = 2'd1;
      end else if (center_row >= ROW_WIDTH'(ZONE2_ROW_MIN)) begin
         zone = 2'd2;
      end else begin
         zone = 2'd3;
      end
   end

   // prewitt gradients and energy
   always_comb begin
      top_sum   = 10'(win_ff[0]) + 10'(win_ff[1]) + 10'(top_px);
      bot_sum   = 10'(win_ff[4]) + 10'(win_ff[5]) + 10'(bot_px);
      left_sum  = 10'(win_ff[0]) + 10'(win_ff[2]) + 10'(win_ff[4]);
      right_sum = 10'(top_px) + 10'(mid_px) + 10'(bot_px);
      dx        = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
      dy        = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
      dx_sq     = dx * dx;
      dy_sq     = dy * dy;
      energy    = 21'(dx_sq[19:0]) + 21'(dy_sq[19:0]);
      is_dark   = win_ff[3] < dark_ff[zone];
      is_strong = energy > 21'(thresh_ff[zone]);
   end

   // result register next state
   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      if (s1_move && s1_has_result) begin
         rsp_valid_in      = 1'b1;
         rsp_in.edge_res   = is_dark && is_strong;
         rsp_in.center_row = center_row;
         rsp_in.center_col = s1_ff.col - COL_WIDTH'(1);
      end
   end

   // stage 1 next valid
   always_comb begin
      s1_valid_in = s1_valid_ff && !s1_move;
      if (req_accept) begin
         s1_valid_in = in_frame;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         s1_fwd_ff    <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            s1_fwd_ff <= s1_valid_ff && (s1_ff.col == req_payload.col);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_accept) begin
         s1_ff           <= req_payload;
         s1_fwd_older_ff <= mid_px;
         s1_fwd_newer_ff <= s1_ff.pixel;
      end
   end

   // window shift
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_move) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= top_px;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= mid_px;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= bot_px;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef NO_ASSERTIONS
   // the request side only stalls behind a held stage
   assert property (@(posedge clock) disable iff (reset) req_stall |-> s1_valid_ff)
      else $error("request stalled with empty stage");

   // a held stage keeps its request
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> s1_valid_ff)
      else $error("held stage lost its request");

   // a new result comes only from an advancing stage
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall) |=> (!rsp_valid_ff || $past(s1_move)))
      else $error("result without stage advance");

   // centres never lie on the first row or column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.center_row != '0) && (rsp_ff.center_col != '0))
      else $error("border pixel classified");
`endif

endmodule

`default_nettype wire
